// ===== rtl/can_bit_timing_search_assert.svh =====
// Assertion macros for the CAN bit timing search RTL.
`ifndef CAN_BIT_TIMING_SEARCH_ASSERT_SVH
`define CAN_BIT_TIMING_SEARCH_ASSERT_SVH

// Immediate implication checked at every clock edge outside reset.
`define CBTS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked at the next clock edge.
`define CBTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cbts_pkg.sv =====
// Shared types and constants of the CAN bit timing search.
package cbts_pkg;

  localparam int unsigned MaxSeg1    = 16;
  localparam int unsigned MaxSeg2    = 8;
  localparam int unsigned MaxDivider = 1024;
  localparam int unsigned SpScale    = 1000;

  localparam int unsigned QuoW   = 11;   // quotient bits the divider produces
  localparam int unsigned DvdW   = 32;   // dividend width
  localparam int unsigned DvsW   = 25;   // divisor width: bitrate times quanta
  localparam int unsigned RateW  = 20;
  localparam int unsigned TgtW   = 10;
  localparam int unsigned Seg1W  = 4;
  localparam int unsigned Seg2W  = 3;
  localparam int unsigned QntW   = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PRE,
    ST_PRE_WAIT,
    ST_SP,
    ST_SP_WAIT,
    ST_EVAL,
    ST_FINISH
  } cbts_state_e;

  typedef struct packed {
    logic              start;
    logic [DvdW-1:0]   dividend;
    logic [DvsW-1:0]   divisor;
  } cbts_div_req_t;

  typedef struct packed {
    logic              done;
    logic              ovf;     // quotient does not fit in QuoW bits
    logic              exact;   // remainder is zero
    logic [QuoW-1:0]   quo;
  } cbts_div_rsp_t;

endpackage

// ===== rtl/cbts_div.sv =====
// Restoring divider producing an 11-bit quotient, one bit per cycle.
module cbts_div
  import cbts_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cbts_div_req_t req_i,
  output cbts_div_rsp_t rsp_o
);

  localparam int unsigned DsW = DvsW + QuoW - 1;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [3:0]          cnt_q;
  logic [DvdW-1:0]     rem_q;
  logic [DsW-1:0]      ds_q;
  logic [QuoW-1:0]     quo_q;
  logic                ovf_q;
  logic                ge;

  assign ge = ({{(DsW-DvdW){1'b0}}, rem_q} >= ds_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
    end else if (busy_q && (cnt_q == 4'd0)) begin
      busy_d = 1'b0;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      if (req_i.start) begin
        cnt_q <= 4'(QuoW - 1);
      end else if (busy_q && (cnt_q != 4'd0)) begin
        cnt_q <= cnt_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.dividend;
      ds_q  <= {req_i.divisor, {(QuoW-1){1'b0}}};
      quo_q <= '0;
      ovf_q <= ({{(QuoW+DvsW-DvdW){1'b0}}, req_i.dividend} >= {req_i.divisor, {QuoW{1'b0}}});
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - ds_q[DvdW-1:0];
      end
      quo_q <= {quo_q[QuoW-2:0], ge};
      ds_q  <= ds_q >> 1;
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.ovf   = ovf_q;
  assign rsp_o.exact = (rem_q == '0);
  assign rsp_o.quo   = quo_q;

endmodule

// ===== rtl/can_bit_timing_search.sv =====
// Top level of the CAN bit timing search: sequencer, best-candidate tracking, output register.
//
// The block finds CAN bit timing for a requested bitrate and sample point.
// cfg_we_i/cfg_wdata_i write the peripheral clock rate in hertz; write it
// only while the block is idle. An item on the slave stream carries the
// bitrate and the target sample point in permille. For every item one
// result item leaves on the master stream: tuser is the found flag, tdata
// holds the prescaler and the segment register fields (zero if not found).
// The search runs over 16 segment-1 by 8 segment-2 lengths, outer loop on
// segment 1. Each candidate uses one shared restoring divider: first
// clock / (bitrate * quanta) for the prescaler and exactness, then, only
// for a kept prescaler, the sample point (1 + seg1) * 1000 / quanta. The
// divider produces one quotient bit per cycle and sets the search time.
// Only one item is in work at a time; s_axis_tready_o is high while idle.
// The finished result sits in an output register, so a new item may be
// accepted while the receiver stalls on the previous result; a second
// result waits until the register frees. Reset clears the clock rate to
// zero and empties the output register.
module can_bit_timing_search
  import cbts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [19:0] bitrate, [29:20] sample_target
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [10:0] prescaler, [14:11] seg1_field,
                                        // [17:15] seg2_field
  output logic        m_axis_tuser_o    // [0] found
);

  cbts_state_e      state_q, state_d;
  logic [31:0]      clock_hz_q;
  logic [RateW-1:0] rate_q;
  logic [TgtW-1:0]  target_q;
  logic [Seg1W-1:0] s1_q;          // segment-1 length minus one
  logic [Seg2W-1:0] s2_q;          // segment-2 length minus one
  logic [DvsW-1:0]  dvs_q;         // bitrate times quanta
  logic [14:0]      spnum_q;       // (1 + seg1) * 1000
  logic [QuoW-1:0]  pres_q;
  logic             ok_q;
  logic             have_q;
  logic [TgtW-1:0]  best_err_q;
  logic [QuoW-1:0]  best_pres_q;
  logic [Seg1W-1:0] best_s1_q;
  logic [Seg2W-1:0] best_s2_q;
  logic             out_valid_q;
  logic [23:0]      out_data_q;
  logic             out_found_q;

  logic [QntW-1:0]  quanta;
  logic             in_acc;
  logic             load_out;
  logic             last_cand;
  logic             pres_ok;
  logic [TgtW-1:0]  sp;
  logic [TgtW-1:0]  err;
  logic             better;
  cbts_div_req_t    div_req;
  cbts_div_rsp_t    div_rsp;
  logic             res_found;     // a found result item is offered
  logic             res_empty;     // a not-found result item is offered
  logic             res_pres_ok;   // offered prescaler lies in the legal range

  cbts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Total quanta: sync quantum plus both segments.
  assign quanta = QntW'(3) + QntW'(s1_q) + QntW'(s2_q);

  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign last_cand = (s1_q == Seg1W'(MaxSeg1 - 1)) && (s2_q == Seg2W'(MaxSeg2 - 1));

  // A candidate is kept only for an exact, in-range prescaler.
  assign pres_ok = !div_rsp.ovf && div_rsp.exact && (div_rsp.quo != '0) &&
                   (div_rsp.quo <= QuoW'(MaxDivider));

  // The sample point never exceeds 1000, so it fits the target width.
  assign sp     = div_rsp.quo[TgtW-1:0];
  assign err    = (sp > target_q) ? (sp - target_q) : (target_q - sp);
  assign better = ok_q && (!have_q || (err < best_err_q));

  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = clock_hz_q;
    div_req.divisor  = dvs_q;
    load_out         = 1'b0;
    s_axis_tready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_PRE;
      end
      ST_PRE: begin
        div_req.start = 1'b1;
        state_d       = ST_PRE_WAIT;
      end
      ST_PRE_WAIT: begin
        if (div_rsp.done) begin
          state_d = pres_ok ? ST_SP : ST_EVAL;
        end
      end
      ST_SP: begin
        div_req.start    = 1'b1;
        div_req.dividend = {17'b0, spnum_q};
        div_req.divisor  = DvsW'(quanta);
        state_d          = ST_SP_WAIT;
      end
      ST_SP_WAIT: begin
        if (div_rsp.done) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = last_cand ? ST_FINISH : ST_MUL;
      end
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clock_hz_q  <= '0;
      out_valid_q <= 1'b0;
      have_q      <= 1'b0;
      s1_q        <= '0;
      s2_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        clock_hz_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc) begin
        have_q <= 1'b0;
        s1_q   <= '0;
        s2_q   <= '0;
      end else if (state_q == ST_EVAL) begin
        if (better) begin
          have_q <= 1'b1;
        end
        // Inner loop over segment 2, outer over segment 1.
        if (s2_q == Seg2W'(MaxSeg2 - 1)) begin
          s2_q <= '0;
          s1_q <= s1_q + Seg1W'(1);
        end else begin
          s2_q <= s2_q + Seg2W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rate_q   <= s_axis_tdata_i[RateW-1:0];
      target_q <= s_axis_tdata_i[RateW+TgtW-1:RateW];
    end
    if (state_q == ST_MUL) begin
      dvs_q   <= DvsW'(rate_q) * DvsW'(quanta);
      spnum_q <= ({11'b0, s1_q} + 15'd2) * 15'(SpScale);
    end
    if ((state_q == ST_PRE_WAIT) && div_rsp.done) begin
      pres_q <= div_rsp.quo;
      ok_q   <= pres_ok;
    end
    if ((state_q == ST_EVAL) && better) begin
      best_err_q  <= err;
      best_pres_q <= pres_q;
      best_s1_q   <= s1_q;
      best_s2_q   <= s2_q;
    end
    if (load_out) begin
      out_found_q <= have_q;
      out_data_q  <= have_q ? {6'b0, best_s2_q, best_s1_q, best_pres_q} : '0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_found_q;

  assign res_found   = m_axis_tvalid_o && m_axis_tuser_o;
  assign res_empty   = m_axis_tvalid_o && !m_axis_tuser_o;
  assign res_pres_ok = (m_axis_tdata_o[QuoW-1:0] != '0) &&
                       (m_axis_tdata_o[QuoW-1:0] <= QuoW'(MaxDivider));

`include "can_bit_timing_search_assert.svh"

  `CBTS_ASSERT_IMPL(a_found_pres, res_found, res_pres_ok, "found result with bad prescaler")
  `CBTS_ASSERT_IMPL(a_notfound_zero, res_empty, m_axis_tdata_o == '0, "nonzero not-found result")
  `CBTS_ASSERT_NEXT(a_busy_after_acc, in_acc, !s_axis_tready_o, "item accepted mid-search")

endmodule

// ===== bench/cbts_timing_checker.sv =====
// Checker that predicts and compares every result item of the CAN bit timing search.
module cbts_timing_checker
  import cbts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [23:0] m_tdata_i,
  input  logic        m_tuser_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o
);

  typedef struct packed {
    logic             found;
    logic [QuoW-1:0]  prescaler;
    logic [Seg1W-1:0] seg1_field;
    logic [Seg2W-1:0] seg2_field;
  } bit_timing_t;

  logic [31:0] clock_hz;
  bit_timing_t pending_timings[$];

  // Exhaustive search in the same order as the hardware: segment 1 outer, segment 2 inner.
  function automatic bit_timing_t best_timing(input logic [31:0]      clk_hz,
                                              input logic [RateW-1:0] rate,
                                              input logic [TgtW-1:0]  target);
    bit_timing_t       best;
    int unsigned       best_err;
    int unsigned       s1;
    int unsigned       s2;
    int unsigned       quanta;
    int unsigned       sp;
    int unsigned       err;
    longint unsigned   divisor;
    longint unsigned   presc;
    best     = '0;
    best_err = 0;
    for (s1 = 1; s1 <= MaxSeg1; s1++) begin
      for (s2 = 1; s2 <= MaxSeg2; s2++) begin
        quanta  = 1 + s1 + s2;
        divisor = longint'(rate) * longint'(quanta);
        if (divisor == 0) continue;
        if ((longint'(clk_hz) % divisor) != 0) continue;
        presc = longint'(clk_hz) / divisor;
        if (presc == 0 || presc > MaxDivider) continue;
        sp  = ((1 + s1) * SpScale) / quanta;
        err = (sp > target) ? (sp - target) : (target - sp);
        if (!best.found || err < best_err) begin
          best.found      = 1'b1;
          best.prescaler  = presc[QuoW-1:0];
          best.seg1_field = Seg1W'(s1 - 1);
          best.seg2_field = Seg2W'(s2 - 1);
          best_err        = err;
        end
      end
    end
    return best;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got, inout int unsigned errors);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bit_timing_t seen;
    bit_timing_t want;
    int unsigned errors;
    if (!rst_ni) begin
      clock_hz <= '0;
      pending_timings.delete();
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
    end else begin
      errors = mismatch_count_o;
      // The result side is handled first, so an item accepted at this edge
      // can never be matched against a result leaving at the same edge.
      if (m_tvalid_i && m_tready_i) begin
        seen.found      = m_tuser_i;
        seen.prescaler  = m_tdata_i[10:0];
        seen.seg1_field = m_tdata_i[14:11];
        seen.seg2_field = m_tdata_i[17:15];
        if (pending_timings.size() == 0) begin
          $display("%0t: result expected none, got found %0d prescaler %0d seg1 %0d seg2 %0d",
                   $time, seen.found, seen.prescaler, seen.seg1_field, seen.seg2_field);
          errors++;
        end else begin
          want = pending_timings.pop_front();
          check_field("found", want.found, seen.found, errors);
          check_field("prescaler", want.prescaler, seen.prescaler, errors);
          check_field("seg1_field", want.seg1_field, seen.seg1_field, errors);
          check_field("seg2_field", want.seg2_field, seen.seg2_field, errors);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        pending_timings.push_back(best_timing(clock_hz, s_tdata_i[19:0], s_tdata_i[29:20]));
      end
      if (cfg_we_i) begin
        clock_hz <= cfg_wdata_i;
      end
      mismatch_count_o <= errors;
      pending_count_o  <= pending_timings.size();
    end
  end

endmodule

// ===== bench/tb_can_bit_timing_search.sv =====
// Testbench top: stimulus, idling and verdict for the CAN bit timing search.
module tb_can_bit_timing_search;
  import cbts_pkg::*;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;

  int unsigned mismatch_count;
  int unsigned pending_count;

  // When set, the matching side runs without gaps for the current phase.
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  can_bit_timing_search dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  cbts_timing_checker timing_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .s_tvalid_i       (s_tvalid),
    .s_tready_i       (s_tready),
    .s_tdata_i        (s_tdata),
    .m_tvalid_i       (m_tvalid),
    .m_tready_i       (m_tready),
    .m_tdata_i        (m_tdata),
    .m_tuser_i        (m_tuser),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // A generous bound: every item at its slowest search plus the longest
  // gaps on both sides stays well inside it.
  initial begin
    #8000000;
    $display("tb_can_bit_timing_search: FAIL");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, 3);
    if (r < 90) return $urandom_range(4, 20);
    return $urandom_range(60, 300);
  endfunction

  // Picks a bitrate that divides the clock into a legal quanta count and
  // prescaler, so that the search finds real candidates. Falls back to an
  // arbitrary bitrate when no try finds a usable divisor.
  function automatic logic [RateW-1:0] fitting_rate(input logic [31:0] clk_hz);
    longint unsigned quanta;
    longint unsigned presc;
    longint unsigned divisor;
    longint unsigned rate;
    int              n;
    for (n = 0; n < 200; n++) begin
      quanta  = $urandom_range(3, 25);
      presc   = $urandom_range(0, 1) ? $urandom_range(1, 32) : $urandom_range(1, 1024);
      divisor = quanta * presc;
      if ((longint'(clk_hz) % divisor) == 0) begin
        rate = longint'(clk_hz) / divisor;
        if (rate >= 1 && rate <= 20'hFFFFF) return rate[RateW-1:0];
      end
    end
    return RateW'($urandom_range(1, 1000000));
  endfunction

  // Presents one request item and holds it until the block takes it. The
  // valid stays high into the next item when no gap follows.
  task automatic push_request(input logic [RateW-1:0] rate, input logic [TgtW-1:0] target);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, target, rate};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    gap = tx_steady ? 0 : pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every predicted result has been taken.
  // The first edge lets the checker count an item accepted at this very edge.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // The clock rate may only change while the block is idle.
  task automatic write_clock(input logic [31:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // The result side stalls at random, except in phases marked steady.
  initial begin : result_sink
    int unsigned hold;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      hold = rx_steady ? 0 : pick_gap();
      if (hold != 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [31:0] clock_plan [9];
    logic [31:0] clk_hz;
    int          phase;
    int          item;
    int          count;
    logic [RateW-1:0] rate;
    logic [TgtW-1:0]  target;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The first request runs on the clock rate left by
    // reset, which is zero, so nothing can be found.
    push_request(20'd125000, 10'd875);

    write_clock(32'd80000000);
    push_request(20'd0, 10'd875);           // zero bitrate: no divisor at all
    push_request(20'd1000000, 10'd875);
    push_request(20'd1000000, 10'd0);       // lowest target
    push_request(20'd500000, 10'd1000);     // highest meaningful target
    push_request(20'd500000, 10'd1023);     // target above the bit time
    push_request(20'd250000, 10'd500);
    push_request(20'd125000, 10'd875);
    push_request(20'd800000, 10'd750);
    push_request(20'd1, 10'd500);           // prescaler far above the limit
    push_request(20'hFFFFF, 10'd500);       // widest bitrate field

    // The all-ones clock factors as 3*5*17*257*65537, so only a few
    // bitrates give an exact division.
    write_clock(32'hFFFFFFFF);
    push_request(20'd983055, 10'd875);
    push_request(20'd983055, 10'd0);
    push_request(20'd65535, 10'd500);
    push_request(20'hFFFFF, 10'd1023);

    write_clock(32'd1);
    push_request(20'd1, 10'd500);

    // Random part: one phase per clock setting. Most requests are built to
    // divide the clock exactly; the rest are arbitrary bitrates.
    clock_plan[0] = 32'd80000000;
    clock_plan[1] = 32'd48000000;
    clock_plan[2] = 32'd36000000;
    clock_plan[3] = 32'hFFFFFFFF;
    clock_plan[4] = 32'd24000000;
    clock_plan[5] = $urandom() & 32'hFFFFF000;
    clock_plan[6] = 32'd16000000;
    clock_plan[7] = 32'd1;
    clock_plan[8] = 32'd0;

    for (phase = 0; phase < 9; phase++) begin
      clk_hz = clock_plan[phase];
      write_clock(clk_hz);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      count = (clk_hz <= 32'd1) ? 6 : 15;
      for (item = 0; item < count; item++) begin
        if ($urandom_range(0, 9) < 8) begin
          rate = fitting_rate(clk_hz);
        end else begin
          rate = RateW'($urandom_range(0, 20'hFFFFF));
        end
        target = TgtW'($urandom_range(0, 1023));
        push_request(rate, target);
        // Now and then the sender holds off until the block has emptied.
        if (item == count / 2 && $urandom_range(0, 1) == 1) begin
          drain();
        end
      end
    end

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    drain();
    // One more search time, so a stray extra result would still be seen.
    repeat (4000) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb_can_bit_timing_search: PASS");
    end else begin
      $display("tb_can_bit_timing_search: FAIL");
    end
    $finish;
  end

endmodule
